>>> rtl/labms_pkg.sv
`timescale 1ns / 1ps
// Package for the local address best-match select block.
// Holds the op codes, register indexes, FSM states and the match-count function.
package labms_pkg;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned MATCH_W  = 6;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [OP_W-1:0] {
		OP_RESOLVE = 2'd0,
		OP_ADD     = 2'd1,
		OP_SELECT  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIX_ENABLED    = 1'b0,
		REG_FORCED_ADDRESS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SCAN  = 2'd1,
		ST_DRAIN = 2'd2,
		ST_DONE  = 2'd3
	} state_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} scan_ctl_t;

	// Number of equal low-order bits, found as trailing zeros of the XOR.
	function automatic logic [MATCH_W-1:0] low_match_bits(logic [ADDR_W-1:0] a,
		logic [ADDR_W-1:0] b);
		logic [ADDR_W-1:0] v;
		logic [MATCH_W-1:0] n;
		v = a ^ b;
		n = '0;
		if (v == '0) begin
			n = MATCH_W'(ADDR_W);
		end else begin
			if (v[15:0] == '0) begin
				n = n + MATCH_W'(16);
				v = v >> 16;
			end
			if (v[7:0] == '0) begin
				n = n + MATCH_W'(8);
				v = v >> 8;
			end
			if (v[3:0] == '0) begin
				n = n + MATCH_W'(4);
				v = v >> 4;
			end
			if (v[1:0] == '0) begin
				n = n + MATCH_W'(2);
				v = v >> 2;
			end
			if (v[0] == 1'b0) begin
				n = n + MATCH_W'(1);
			end
		end
		return n;
	endfunction

endpackage

>>> rtl/labms_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the local address best-match select block.
// Depends on labms_pkg for field widths.
interface labms_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [labms_pkg::OP_W-1:0]            op;
	logic [labms_pkg::ADDR_W-1:0]          address;
	logic [labms_pkg::ADDR_W-1:0]          current_local;

	modport source (output valid, op, address, current_local, input ready);
	modport sink   (input valid, op, address, current_local, output ready);
endinterface

interface labms_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [labms_pkg::ADDR_W-1:0]          chosen_address;
	logic                                  replaced;
	logic [labms_pkg::MATCH_W-1:0]         bits_matched;
	logic                                  add_dropped;

	modport source (output valid, chosen_address, replaced, bits_matched, add_dropped,
		input ready);
	modport sink   (input valid, chosen_address, replaced, bits_matched, add_dropped,
		output ready);
endinterface

interface labms_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [labms_pkg::CFG_IDX_W-1:0]       index;
	logic [labms_pkg::ADDR_W-1:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/labms_table.sv
`timescale 1ns / 1ps
// Address table memory: one write port, one read port with registered data.
// Depends on labms_pkg for the address width.
module labms_table #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [labms_pkg::ADDR_W-1:0] wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [labms_pkg::ADDR_W-1:0] rdata
);

	logic [labms_pkg::ADDR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/labms_scan.sv
`timescale 1ns / 1ps
// Best-match tracker: compares each word read from the table with the remote
// address and keeps the first entry with the longest low-order match. Uses labms_pkg.
module labms_scan (
	input  logic                          clk,
	input  labms_pkg::scan_ctl_t          ctl,
	input  logic [labms_pkg::ADDR_W-1:0]  remote,
	input  logic [labms_pkg::ADDR_W-1:0]  entry,
	output logic [labms_pkg::ADDR_W-1:0]  best,
	output logic [labms_pkg::MATCH_W-1:0] bits
);

	logic [labms_pkg::ADDR_W-1:0]  best_q;
	logic [labms_pkg::MATCH_W-1:0] bits_q;
	logic [labms_pkg::MATCH_W-1:0] match;

	assign match = labms_pkg::low_match_bits(remote, entry);

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			best_q <= '0;
			bits_q <= '0;
		end else if (ctl.valid && (match > bits_q)) begin
			best_q <= entry;
			bits_q <= match;
		end
	end

	assign best = best_q;
	assign bits = bits_q;

endmodule

>>> rtl/local_address_best_match_select.sv
`timescale 1ns / 1ps
// Local address best-match select, top level. Resolve, add and pass-through words go
// from idle to the done state, which loads the output register; a select on a non-empty
// table first scans it one entry per cycle through its single read port, then drains
// the last read. One word is in work at a time; the output register lets the next word
// be taken while a result waits. Reset clears the control state, the entry count and
// the registers (fix_enabled to 1, forced_address to 0); table contents stay undefined.
module local_address_best_match_select #(
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	labms_req_if.sink    req,
	labms_rsp_if.source  rsp,
	labms_cfg_if.sink    cfg
);

	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	labms_pkg::state_t              state_q;
	labms_pkg::state_t              state_d;
	logic [CW-1:0]                  count_q;
	logic                           fix_q;
	logic [labms_pkg::ADDR_W-1:0]   forced_q;
	logic [AW-1:0]                  rd_idx_q;
	logic                           rd_valid_s1;
	logic [labms_pkg::ADDR_W-1:0]   remote_q;
	logic [labms_pkg::ADDR_W-1:0]   cur_q;
	logic [labms_pkg::ADDR_W-1:0]   chosen_q;
	logic                           sel_q;
	logic                           dropped_q;

	logic                           out_valid_q;
	logic [labms_pkg::ADDR_W-1:0]   out_chosen_q;
	logic                           out_replaced_q;
	logic [labms_pkg::MATCH_W-1:0]  out_bits_q;
	logic                           out_dropped_q;

	logic                           accept;
	logic                           full;
	logic                           rd_last;
	logic                           mem_re;
	logic                           mem_we;
	logic                           out_load;
	logic                           start_scan;
	logic                           is_select;
	logic                           clear_tbl;
	logic                           drop;
	logic [labms_pkg::ADDR_W-1:0]   chosen_d;
	logic [labms_pkg::ADDR_W-1:0]   mem_rdata;
	logic [labms_pkg::ADDR_W-1:0]   best;
	logic [labms_pkg::MATCH_W-1:0]  bits;
	logic [labms_pkg::ADDR_W-1:0]   res_chosen;
	labms_pkg::scan_ctl_t           scan_ctl;

	assign accept  = req.valid && req.ready;
	assign full    = (count_q == CW'(TABLE_ENTRIES));
	assign rd_last = (CW'(rd_idx_q) == (count_q - CW'(1)));
	assign cfg.ready = 1'b1;

	// Decode of an accepted word.
	always_comb begin
		is_select = 1'b0;
		clear_tbl = 1'b0;
		mem_we    = 1'b0;
		drop      = 1'b0;
		chosen_d  = req.current_local;
		if (accept && fix_q) begin
			case (labms_pkg::op_t'(req.op))
				labms_pkg::OP_RESOLVE: begin
					clear_tbl = 1'b1;
					if (forced_q != '0) begin
						chosen_d = forced_q;
					end
				end
				labms_pkg::OP_ADD: begin
					if (forced_q == '0) begin
						mem_we = !full;
						drop   = full;
					end
				end
				labms_pkg::OP_SELECT: begin
					is_select = 1'b1;
				end
				default: begin
					is_select = 1'b0;
				end
			endcase
		end
	end

	assign start_scan = is_select && (count_q != '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			labms_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = start_scan ? labms_pkg::ST_SCAN : labms_pkg::ST_DONE;
				end
			end
			labms_pkg::ST_SCAN: begin
				if (rd_last) begin
					state_d = labms_pkg::ST_DRAIN;
				end
			end
			labms_pkg::ST_DRAIN: begin
				state_d = labms_pkg::ST_DONE;
			end
			labms_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = labms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = labms_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		mem_re    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			labms_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			labms_pkg::ST_SCAN: begin
				mem_re = 1'b1;
			end
			labms_pkg::ST_DRAIN: begin
				mem_re = 1'b0;
			end
			labms_pkg::ST_DONE: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= labms_pkg::ST_IDLE;
			count_q     <= '0;
			fix_q       <= 1'b1;
			forced_q    <= '0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= mem_re;
			if (cfg.valid && cfg.ready) begin
				case (labms_pkg::reg_idx_t'(cfg.index))
					labms_pkg::REG_FIX_ENABLED:    fix_q    <= cfg.data[0];
					labms_pkg::REG_FORCED_ADDRESS: forced_q <= cfg.data;
					default:                       fix_q    <= fix_q;
				endcase
			end
			if (clear_tbl) begin
				count_q <= '0;
			end else if (mem_we) begin
				count_q <= count_q + CW'(1);
			end
			if (accept) begin
				rd_idx_q <= '0;
			end else if (mem_re) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			remote_q  <= req.address;
			cur_q     <= req.current_local;
			chosen_q  <= chosen_d;
			sel_q     <= is_select;
			dropped_q <= drop;
		end
	end

	assign res_chosen = (sel_q && (best != '0) && (best != cur_q)) ? best : chosen_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_chosen_q   <= res_chosen;
			out_replaced_q <= (res_chosen != cur_q);
			out_bits_q     <= sel_q ? bits : '0;
			out_dropped_q  <= dropped_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.chosen_address = out_chosen_q;
	assign rsp.replaced       = out_replaced_q;
	assign rsp.bits_matched   = out_bits_q;
	assign rsp.add_dropped    = out_dropped_q;

	// The table is written only from the idle state and read only while scanning,
	// so a read never overlaps a write to the same entry.
	labms_table #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (req.address),
		.re    (mem_re),
		.raddr (rd_idx_q),
		.rdata (mem_rdata)
	);

	assign scan_ctl.clear = accept;
	assign scan_ctl.valid = rd_valid_s1;

	labms_scan u_scan (
		.clk    (clk),
		.ctl    (scan_ctl),
		.remote (remote_q),
		.entry  (mem_rdata),
		.best   (best),
		.bits   (bits)
	);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("entry count exceeds table depth");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (count_q != '0))
		else $error("table write did not advance the entry count");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (CW'(rd_idx_q) < count_q))
		else $error("table read beyond valid entries");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.add_dropped) |-> ((rsp.bits_matched == '0) && !rsp.replaced))
		else $error("dropped add reported a match or replacement");
`endif

endmodule
